[hw/rtl/alle_pkg.sv]
package alle_pkg;

    localparam int Depth = 16;
    localparam int IdxW = 4;
    localparam int LnkW = 5;
    localparam int CapW = 5;
    localparam int QDepth = 2;

    localparam logic [31:0] FreeVal = 32'hFFFF_FFFF;
    localparam logic [LnkW-1:0] LnkNil = '1;
    localparam logic [7:0] IdxNone = 8'hFF;
    localparam logic [CapW-1:0] CapReset = CapW'(16);

    typedef enum logic [1:0] {
        FN_INSERT = 2'd0,
        FN_DELETE = 2'd1,
        FN_FIND   = 2'd2,
        FN_FIRST  = 2'd3
    } t_func;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_FULL     = 3'd1,
        ST_NOTFOUND = 3'd2,
        ST_EMPTY    = 3'd3,
        ST_RESERVED = 3'd4
    } t_status;

    typedef struct packed {
        logic [1:0]  func;
        logic [31:0] data;
    } t_in;

    typedef struct packed {
        logic [2:0]  status;
        logic [31:0] value;
        logic [7:0]  node_index;
    } t_out;

    // classified command from front to back
    typedef struct packed {
        logic        reserved;
        t_func       func;
        logic [31:0] data;
    } t_cmd;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_WALK,
        S_LINK,
        S_UNLINK,
        S_RESULT
    } t_state;

endpackage

[hw/rtl/alle_front.sv]
module alle_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  alle_pkg::t_in    i_in_data,
    output logic             o_cmd_valid,
    input  logic             i_cmd_ready,
    output alle_pkg::t_cmd   o_cmd
);
    import alle_pkg::*;

    t_cmd r_q [QDepth];
    logic r_wp, r_rp;
    logic [1:0] r_cnt, n_cnt;
    t_cmd w_cmd;
    logic w_push, w_pop;

    always_comb begin
        w_cmd.func = t_func'(i_in_data.func);
        w_cmd.data = i_in_data.data;
        w_cmd.reserved = (t_func'(i_in_data.func) != FN_FIRST) &&
                         (i_in_data.data == FreeVal);
    end

    assign o_in_ready = (r_cnt != 2'(QDepth));
    assign w_push = i_in_valid && o_in_ready;
    assign o_cmd_valid = (r_cnt != 2'd0);
    assign w_pop = o_cmd_valid && i_cmd_ready;
    assign o_cmd = r_q[r_rp];

    always_comb begin
        n_cnt = r_cnt;
        if (w_push && !w_pop) begin
            n_cnt = r_cnt + 2'd1;
        end else if (!w_push && w_pop) begin
            n_cnt = r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= 1'b0;
            r_rp <= 1'b0;
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
            if (w_push) begin
                r_wp <= ~r_wp;
            end
            if (w_pop) begin
                r_rp <= ~r_rp;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wp] <= w_cmd;
        end
    end

endmodule

[hw/rtl/alle_back.sv]
module alle_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_valid,
    output logic             o_cfg_ready,
    input  logic [4:0]       i_cfg_data,
    input  logic             i_cmd_valid,
    output logic             o_cmd_ready,
    input  alle_pkg::t_cmd   i_cmd,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output alle_pkg::t_out   o_out_data
);
    import alle_pkg::*;

    // node store in flops: reset frees everything
    logic [31:0]     r_val  [Depth];
    logic [LnkW-1:0] r_prv  [Depth];
    logic [LnkW-1:0] r_nxt  [Depth];
    logic [LnkW-1:0] r_head;
    logic [CapW-1:0] r_cnt;
    logic [CapW-1:0] r_cap;

    t_state r_state, n_state;
    t_cmd   r_cmd;
    logic [LnkW-1:0] r_idx, n_idx;
    logic [CapW-1:0] r_step, n_step;
    logic [CapW-1:0] w_lim;
    t_out   r_out, n_out;
    logic   w_take, w_cur_node, w_head_node;
    logic [IdxW-1:0] w_ci;

    assign o_cfg_ready = 1'b1;
    assign o_cmd_ready = (r_state == S_IDLE);
    assign w_take = i_cmd_valid && o_cmd_ready;
    assign o_out_valid = (r_state == S_RESULT);
    assign o_out_data = r_out;
    assign w_lim = (r_cap < CapW'(Depth)) ? r_cap : CapW'(Depth);
    assign w_cur_node = (r_idx < LnkW'(Depth));
    assign w_head_node = (r_head < LnkW'(Depth));
    assign w_ci = r_idx[IdxW-1:0];

    function automatic t_out fail(input t_status st);
        t_out o;
        o.status = st;
        o.value = FreeVal;
        o.node_index = IdxNone;
        return o;
    endfunction

    always_comb begin
        n_state = r_state;
        n_idx = r_idx;
        n_step = r_step;
        n_out = r_out;
        case (r_state)
            S_IDLE: begin
                if (w_take) begin
                    n_step = '0;
                    n_idx = r_head;
                    if (i_cmd.func == FN_FIRST) begin
                        n_state = S_RESULT;
                        n_out = w_head_node ?
                            t_out'{ST_OK, r_val[r_head[IdxW-1:0]], 8'(r_head)} :
                            fail(ST_EMPTY);
                    end else if (i_cmd.reserved) begin
                        n_state = S_RESULT;
                        n_out = fail(ST_RESERVED);
                    end else if (i_cmd.func == FN_INSERT) begin
                        n_idx = '0;
                        if (r_cnt < w_lim) begin
                            n_state = S_SCAN;
                        end else begin
                            n_state = S_RESULT;
                            n_out = fail(ST_FULL);
                        end
                    end else if (!w_head_node) begin
                        n_state = S_RESULT;
                        n_out = fail(ST_EMPTY);
                    end else begin
                        n_state = S_WALK;
                    end
                end
            end
            S_SCAN: begin
                if (r_idx >= LnkW'(w_lim)) begin
                    n_state = S_RESULT;
                    n_out = fail(ST_FULL);
                end else if (r_val[w_ci] == FreeVal) begin
                    n_state = S_LINK;
                end else begin
                    n_idx = r_idx + LnkW'(1);
                end
            end
            S_WALK: begin
                if (!w_cur_node || r_step >= CapW'(Depth)) begin
                    n_state = S_RESULT;
                    n_out = fail(ST_NOTFOUND);
                end else if (r_val[w_ci] == r_cmd.data) begin
                    if (r_cmd.func == FN_FIND) begin
                        n_state = S_RESULT;
                        n_out = t_out'{ST_OK, r_cmd.data, 8'(r_idx)};
                    end else begin
                        n_state = S_UNLINK;
                    end
                end else begin
                    n_idx = r_nxt[w_ci];
                    n_step = r_step + CapW'(1);
                end
            end
            S_LINK, S_UNLINK: begin
                n_state = S_RESULT;
                n_out = t_out'{ST_OK, r_cmd.data, 8'(r_idx)};
            end
            S_RESULT: begin
                if (i_out_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    logic [LnkW-1:0] w_p, w_n;
    assign w_p = r_prv[w_ci];
    assign w_n = r_nxt[w_ci];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_head <= LnkNil;
            r_cnt <= '0;
            r_cap <= CapReset;
            for (int i = 0; i < Depth; i++) begin
                r_val[i] <= FreeVal;
                r_prv[i] <= LnkNil;
                r_nxt[i] <= LnkNil;
            end
        end else begin
            r_state <= n_state;
            if (i_cfg_valid) begin
                r_cap <= i_cfg_data;
            end
            if (r_state == S_LINK) begin
                r_val[w_ci] <= r_cmd.data;
                r_prv[w_ci] <= LnkNil;
                r_nxt[w_ci] <= w_head_node ? r_head : LnkNil;
                if (w_head_node) begin
                    r_prv[r_head[IdxW-1:0]] <= r_idx;
                end
                r_head <= r_idx;
                r_cnt <= r_cnt + CapW'(1);
            end
            if (r_state == S_UNLINK) begin
                if (w_p < LnkW'(Depth)) begin
                    r_nxt[w_p[IdxW-1:0]] <= (w_n < LnkW'(Depth)) ? w_n : LnkNil;
                end else begin
                    r_head <= (w_n < LnkW'(Depth)) ? w_n : LnkNil;
                end
                if (w_n < LnkW'(Depth)) begin
                    r_prv[w_n[IdxW-1:0]] <= (w_p < LnkW'(Depth)) ? w_p : LnkNil;
                end
                r_val[w_ci] <= FreeVal;
                r_prv[w_ci] <= LnkNil;
                r_nxt[w_ci] <= LnkNil;
                if (r_cnt != '0) begin
                    r_cnt <= r_cnt - CapW'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx <= n_idx;
        r_step <= n_step;
        r_out <= n_out;
        if (w_take) begin
            r_cmd <= i_cmd;
        end
    end

endmodule

[hw/rtl/array_linked_list_engine.sv]
// channel | dir | handshake              | payload
// in      | in  | i_in_valid/o_in_ready  | i_in_data  (t_in: func, data)
// out     | out | o_out_valid/i_out_ready| o_out_data (t_out: status, value, node_index)
// cfg     | in  | i_cfg_valid/o_cfg_ready| i_cfg_data (capacity)
// Items pass a two-entry queue into a sequencer that handles one at a time.
// First and rejected items go straight to the result; insert scans one node a
// cycle and find/delete walk one linked node a cycle, up to Depth nodes.
// Synchronous active-low reset empties the list; no clearing pass.
// Output holds in its register until taken; the queue keeps accepting until full.
module array_linked_list_engine (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  alle_pkg::t_in     i_in_data,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output alle_pkg::t_out    o_out_data,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [4:0]        i_cfg_data
);
    import alle_pkg::*;

    t_cmd w_cmd;
    logic w_cmd_valid, w_cmd_ready;

    alle_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_ready(o_in_ready), .i_in_data(i_in_data),
        .o_cmd_valid(w_cmd_valid), .i_cmd_ready(w_cmd_ready), .o_cmd(w_cmd)
    );

    alle_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready), .i_cfg_data(i_cfg_data),
        .i_cmd_valid(w_cmd_valid), .o_cmd_ready(w_cmd_ready), .i_cmd(w_cmd),
        .o_out_valid(o_out_valid), .i_out_ready(i_out_ready), .o_out_data(o_out_data)
    );

endmodule
